@@ rtl/png_pe_pkg.sv @@
// ----------------------------------------------------------------------------
// png_pe_pkg
// Shared types and constants for the PNG palette extractor.
// ----------------------------------------------------------------------------
package png_pe_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int OQ_DEPTH            = 4;

  localparam logic [3:0]  SIG_BYTES       = 4'h8;
  localparam logic [3:0]  SIG_CHECK_END   = 4'h4;
  localparam logic [31:0] TYPE_IHDR       = 32'h4948_4452;
  localparam logic [31:0] TYPE_PLTE       = 32'h504C_5445;
  localparam logic [7:0]  ALPHA_BYTE      = 8'h01;
  localparam logic [31:0] COLOR_TYPE_OFS  = 32'h9;
  localparam logic [7:0]  COLOR_INDEXED   = 8'd3;
  localparam logic [31:0] FIELD_BYTES     = 32'd4;

  typedef enum logic [1:0] {
    PH_LENGTH = 2'd0,
    PH_TYPE   = 2'd1,
    PH_DATA   = 2'd2,
    PH_CRC    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND      = 2'd0,
    ST_NOT_PNG    = 2'd1,
    ST_NO_PALETTE = 2'd2
  } status_t;

  typedef enum logic {
    KIND_ENTRY  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  entry_index;
    logic [31:0] entry_word;
    logic [1:0]  status;
    logic        last_result;
  } result_t;

  // results produced by one accepted byte
  typedef struct packed {
    result_t    res0;
    result_t    res1;
    logic [1:0] push_cnt;
  } push_t;

endpackage

@@ rtl/png_pe_ifs.sv @@
// ----------------------------------------------------------------------------
// png_pe_ifs
// Valid/ready channel interfaces for file bytes and extractor results.
// ----------------------------------------------------------------------------
interface png_pe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       last_byte;

  modport source (output valid, output file_byte, output last_byte, input ready);
  modport sink   (input valid, input file_byte, input last_byte, output ready);
endinterface

interface png_pe_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  entry_index;
  logic [31:0] entry_word;
  logic [1:0]  status;
  logic        last_result;

  modport source (output valid, output result_kind, output entry_index,
                  output entry_word, output status, output last_result,
                  input ready);
  modport sink   (input valid, input result_kind, input entry_index,
                  input entry_word, input status, input last_result,
                  output ready);
endinterface

@@ rtl/png_palette_extractor.sv @@
// Latency: if the queue is empty, a result is offered the cycle after its byte.
// Throughput: one byte per cycle while the queue has room; the byte count, not
// the result count, sets it, except that a final byte completing a triple yields
// two results at once. The parse is a single registered state update per byte;
// results sit in a four-entry queue. Synchronous reset returns the parser to the
// start of a file and empties the queue.
// ----------------------------------------------------------------------------
// png_palette_extractor
// Byte-serial PNG parser giving PLTE entries as ABGR words and a file status.
// ----------------------------------------------------------------------------
module png_palette_extractor #(
  parameter int PALETTE_ENTRIES = png_pe_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  png_pe_byte_if.sink     bytes,
  png_pe_result_if.source results
);
  import png_pe_pkg::*;

  push_t   push;
  result_t head;
  logic    room;
  logic    accept;

  assign bytes.ready = room;
  assign accept      = bytes.valid & room;

  png_pe_walker #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .file_byte (bytes.file_byte),
    .last_byte (bytes.last_byte),
    .push      (push)
  );

  png_pe_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (head)
  );

  assign results.result_kind = head.result_kind;
  assign results.entry_index = head.entry_index;
  assign results.entry_word  = head.entry_word;
  assign results.status      = head.status;
  assign results.last_result = head.last_result;

endmodule

@@ rtl/png_pe_walker.sv @@
// ----------------------------------------------------------------------------
// png_pe_walker
// Signature check and chunk walk; builds palette entries and end status.
// ----------------------------------------------------------------------------
module png_pe_walker #(
  parameter int PALETTE_ENTRIES = png_pe_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          file_byte,
  input  logic                last_byte,
  output png_pe_pkg::push_t   push
);
  import png_pe_pkg::*;

  localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] ENTRY_MAX = CNT_W'(PALETTE_ENTRIES);

  logic [3:0]       header_position, header_position_next;
  logic             signature_good, signature_good_next;
  phase_t           chunk_phase, chunk_phase_next;
  logic [31:0]      field_counter, field_counter_next;
  logic [31:0]      chunk_length, chunk_length_next;
  logic [31:0]      chunk_type, chunk_type_next;
  logic             indexed_seen, indexed_seen_next;
  logic             walk_stopped, walk_stopped_next;
  logic [7:0]       red_latch, red_latch_next;
  logic [7:0]       green_latch, green_latch_next;
  logic [1:0]       triple_position, triple_position_next;
  logic [CNT_W-1:0] entry_counter, entry_counter_next;
  logic             palette_found, palette_found_next;

  logic [31:0] fc_inc;
  logic [31:0] len_shift;
  logic        entry_made;
  logic [8:0]  idx_wide;
  result_t     entry_res;
  result_t     status_res;
  status_t     st;

  assign fc_inc    = field_counter + 32'd1;
  assign len_shift = {chunk_length[23:0], file_byte};
  assign idx_wide  = 9'(entry_counter);

  always_comb begin
    header_position_next = header_position;
    signature_good_next  = signature_good;
    chunk_phase_next     = chunk_phase;
    field_counter_next   = field_counter;
    chunk_length_next    = chunk_length;
    chunk_type_next      = chunk_type;
    indexed_seen_next    = indexed_seen;
    walk_stopped_next    = walk_stopped;
    red_latch_next       = red_latch;
    green_latch_next     = green_latch;
    triple_position_next = triple_position;
    entry_counter_next   = entry_counter;
    palette_found_next   = palette_found;
    entry_made           = 1'b0;
    st                   = ST_NO_PALETTE;

    if (accept) begin
      if (header_position < SIG_BYTES) begin
        if ((header_position == 4'd1 && file_byte != 8'h50) ||
            (header_position == 4'd2 && file_byte != 8'h4E) ||
            (header_position == 4'd3 && file_byte != 8'h47)) begin
          signature_good_next = 1'b0;
        end
        header_position_next = header_position + 4'd1;
      end else if (signature_good && !walk_stopped) begin
        unique case (chunk_phase)
          PH_LENGTH: begin
            chunk_length_next  = len_shift;
            field_counter_next = fc_inc;
            if (fc_inc == FIELD_BYTES) begin
              field_counter_next = '0;
              if (len_shift == 32'd0) begin
                walk_stopped_next = 1'b1;
              end else begin
                chunk_phase_next = PH_TYPE;
              end
            end
          end
          PH_TYPE: begin
            chunk_type_next    = {chunk_type[23:0], file_byte};
            field_counter_next = fc_inc;
            if (fc_inc == FIELD_BYTES) begin
              field_counter_next   = '0;
              triple_position_next = '0;
              entry_counter_next   = '0;
              chunk_phase_next     = PH_DATA;
            end
          end
          PH_DATA: begin
            if (chunk_type == TYPE_IHDR && field_counter == COLOR_TYPE_OFS &&
                file_byte == COLOR_INDEXED) begin
              indexed_seen_next = 1'b1;
            end
            if (chunk_type == TYPE_PLTE && indexed_seen) begin
              priority if (triple_position == 2'd0) begin
                red_latch_next       = file_byte;
                triple_position_next = 2'd1;
              end else if (triple_position == 2'd1) begin
                green_latch_next     = file_byte;
                triple_position_next = 2'd2;
              end else begin
                triple_position_next = 2'd0;
                if (entry_counter < ENTRY_MAX) begin
                  entry_made         = 1'b1;
                  entry_counter_next = entry_counter + CNT_W'(1);
                  palette_found_next = 1'b1;
                end
              end
            end
            field_counter_next = fc_inc;
            if (fc_inc == chunk_length) begin
              field_counter_next = '0;
              chunk_phase_next   = PH_CRC;
            end
          end
          PH_CRC: begin
            field_counter_next = fc_inc;
            if (fc_inc >= FIELD_BYTES) begin
              field_counter_next = '0;
              chunk_length_next  = '0;
              chunk_type_next    = '0;
              chunk_phase_next   = PH_LENGTH;
            end
          end
          default: ;
        endcase
      end

      if (last_byte) begin
        priority if (!signature_good_next || header_position_next < SIG_CHECK_END) begin
          st = ST_NOT_PNG;
        end else if (palette_found_next) begin
          st = ST_FOUND;
        end else begin
          st = ST_NO_PALETTE;
        end
        // file done: back to the reset state
        header_position_next = '0;
        signature_good_next  = 1'b1;
        chunk_phase_next     = PH_LENGTH;
        field_counter_next   = '0;
        chunk_length_next    = '0;
        chunk_type_next      = '0;
        indexed_seen_next    = 1'b0;
        walk_stopped_next    = 1'b0;
        red_latch_next       = '0;
        green_latch_next     = '0;
        triple_position_next = '0;
        entry_counter_next   = '0;
        palette_found_next   = 1'b0;
      end
    end
  end

  always_comb begin
    entry_res.result_kind = KIND_ENTRY;
    entry_res.entry_index = idx_wide[7:0];
    entry_res.entry_word  = {ALPHA_BYTE, file_byte, green_latch, red_latch};
    entry_res.status      = ST_FOUND;
    entry_res.last_result = 1'b0;

    status_res.result_kind = KIND_STATUS;
    status_res.entry_index = '0;
    status_res.entry_word  = '0;
    status_res.status      = st;
    status_res.last_result = 1'b1;

    push.res0     = entry_made ? entry_res : status_res;
    push.res1     = status_res;
    push.push_cnt = {1'b0, entry_made} + {1'b0, accept & last_byte};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= '0;
      signature_good  <= 1'b1;
      chunk_phase     <= PH_LENGTH;
      field_counter   <= '0;
      chunk_length    <= '0;
      chunk_type      <= '0;
      indexed_seen    <= 1'b0;
      walk_stopped    <= 1'b0;
      red_latch       <= '0;
      green_latch     <= '0;
      triple_position <= '0;
      entry_counter   <= '0;
      palette_found   <= 1'b0;
    end else begin
      header_position <= header_position_next;
      signature_good  <= signature_good_next;
      chunk_phase     <= chunk_phase_next;
      field_counter   <= field_counter_next;
      chunk_length    <= chunk_length_next;
      chunk_type      <= chunk_type_next;
      indexed_seen    <= indexed_seen_next;
      walk_stopped    <= walk_stopped_next;
      red_latch       <= red_latch_next;
      green_latch     <= green_latch_next;
      triple_position <= triple_position_next;
      entry_counter   <= entry_counter_next;
      palette_found   <= palette_found_next;
    end
  end

endmodule

@@ rtl/png_pe_outq.sv @@
// ----------------------------------------------------------------------------
// png_pe_outq
// Small result queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module png_pe_outq (
  input  logic               clk,
  input  logic               rst,
  input  png_pe_pkg::push_t  push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output png_pe_pkg::result_t out_data
);
  import png_pe_pkg::*;

  localparam int PTR_W = $clog2(OQ_DEPTH);
  localparam int CNT_W = $clog2(OQ_DEPTH + 1);

  result_t          mem [OQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic [PTR_W-1:0] wr_ptr_1;
  logic             pop;

  assign wr_ptr_1  = wr_ptr + PTR_W'(1);
  assign pop       = out_valid & out_ready;
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  // keep space for the two results one byte can cause
  assign room      = (count <= CNT_W'(OQ_DEPTH - 2));

  always_comb begin
    wr_ptr_next = wr_ptr + PTR_W'(push.push_cnt);
    rd_ptr_next = rd_ptr + PTR_W'(pop);
    count_next  = count + CNT_W'(push.push_cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push_cnt != 2'd0) begin
      mem[wr_ptr] <= push.res0;
    end
    if (push.push_cnt == 2'd2) begin
      mem[wr_ptr_1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams PNG-like files into the palette extractor one byte per transfer,
// tracks the parser state alongside it and checks every palette entry and
// end-of-file status, with random stalls on both channels, long ones on results.
// ----------------------------------------------------------------------------
module tb_top;
  import png_pe_pkg::*;

  localparam int          PAL_ENTRIES  = PALETTE_ENTRIES_DEF;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 8;
  localparam logic [63:0] PNG_MAGIC    = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [7:0]  CHAR_P       = 8'h50;
  localparam logic [7:0]  CHAR_N       = 8'h4E;
  localparam logic [7:0]  CHAR_G       = 8'h47;
  localparam logic [31:0] TYPE_IHDR_LC = 32'h6968_6472;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst;

  png_pe_byte_if   byte_ch ();
  png_pe_result_if result_ch ();

  png_palette_extractor #(
    .PALETTE_ENTRIES(PAL_ENTRIES)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_ch),
    .results (result_ch)
  );

  int src_idle;
  int snk_idle;
  int hold_request;
  int bytes_sent;
  int mismatches;
  int stall_cycles;

  result_t palette_results_due[$];

  // parser state mirrored from the byte stream
  logic [3:0]  sig_pos;
  logic        sig_ok;
  phase_t      phase;
  logic [31:0] field_cnt;
  logic [31:0] chunk_len;
  logic [31:0] chunk_type;
  logic        indexed;
  logic        walk_done;
  logic [7:0]  red_byte;
  logic [7:0]  green_byte;
  logic [1:0]  triple_pos;
  logic [8:0]  entry_cnt;
  logic        pal_found;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic clear_tracker();
    sig_pos    = '0;
    sig_ok     = 1'b1;
    phase      = PH_LENGTH;
    field_cnt  = '0;
    chunk_len  = '0;
    chunk_type = '0;
    indexed    = 1'b0;
    walk_done  = 1'b0;
    red_byte   = '0;
    green_byte = '0;
    triple_pos = '0;
    entry_cnt  = '0;
    pal_found  = 1'b0;
  endtask

  task automatic track_png_byte(input logic [7:0] b, input logic last);
    result_t r;
    if (sig_pos < SIG_BYTES) begin
      if ((sig_pos == 4'd1 && b != CHAR_P) || (sig_pos == 4'd2 && b != CHAR_N) ||
          (sig_pos == 4'd3 && b != CHAR_G))
        sig_ok = 1'b0;
      sig_pos++;
    end else if (sig_ok && !walk_done) begin
      case (phase)
        PH_LENGTH: begin
          chunk_len = {chunk_len[23:0], b};
          field_cnt++;
          if (field_cnt == FIELD_BYTES) begin
            field_cnt = '0;
            if (chunk_len == '0) walk_done = 1'b1;
            else phase = PH_TYPE;
          end
        end
        PH_TYPE: begin
          chunk_type = {chunk_type[23:0], b};
          field_cnt++;
          if (field_cnt == FIELD_BYTES) begin
            field_cnt  = '0;
            triple_pos = '0;
            entry_cnt  = '0;
            phase      = PH_DATA;
          end
        end
        PH_DATA: begin
          if (chunk_type == TYPE_IHDR && field_cnt == COLOR_TYPE_OFS && b == COLOR_INDEXED)
            indexed = 1'b1;
          if (chunk_type == TYPE_PLTE && indexed) begin
            case (triple_pos)
              2'd0: begin
                red_byte   = b;
                triple_pos = 2'd1;
              end
              2'd1: begin
                green_byte = b;
                triple_pos = 2'd2;
              end
              default: begin
                triple_pos = 2'd0;
                // slots past the palette size are dropped
                if (entry_cnt < PAL_ENTRIES) begin
                  r             = '0;
                  r.result_kind = KIND_ENTRY;
                  r.entry_index = entry_cnt[7:0];
                  r.entry_word  = {ALPHA_BYTE, b, green_byte, red_byte};
                  palette_results_due.insert(palette_results_due.size(), r);
                  entry_cnt++;
                  pal_found = 1'b1;
                end
              end
            endcase
          end
          field_cnt++;
          if (field_cnt == chunk_len) begin
            field_cnt = '0;
            phase     = PH_CRC;
          end
        end
        default: begin
          field_cnt++;
          if (field_cnt >= FIELD_BYTES) begin
            field_cnt  = '0;
            chunk_len  = '0;
            chunk_type = '0;
            phase      = PH_LENGTH;
          end
        end
      endcase
    end
    if (last) begin
      r             = '0;
      r.result_kind = KIND_STATUS;
      r.last_result = 1'b1;
      if (!sig_ok || sig_pos < SIG_CHECK_END) r.status = ST_NOT_PNG;
      else if (pal_found) r.status = ST_FOUND;
      else r.status = ST_NO_PALETTE;
      palette_results_due.insert(palette_results_due.size(), r);
      clear_tracker();
    end
  endtask

  // ---- result side -----------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (result_ch.valid && result_ch.ready) begin
        if (palette_results_due.size() == 0) begin
          $error("result transfer with nothing pending: kind %0d status %0d",
                 result_ch.result_kind, result_ch.status);
          mismatches++;
        end else begin
          want = palette_results_due.pop_front();
          check_field("result_kind", want.result_kind, result_ch.result_kind);
          check_field("entry_index", want.entry_index, result_ch.entry_index);
          check_field("entry_word", want.entry_word, result_ch.entry_word);
          check_field("status", want.status, result_ch.status);
          check_field("last_result", want.last_result, result_ch.last_result);
        end
      end
    end
  end

  // receiver: random stalls, or a counted hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // ---- byte side ---------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < src_idle) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.file_byte <= b;
    byte_ch.last_byte <= last;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
    track_png_byte(b, last);
  endtask

  task automatic send_file(input byte_q_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  task automatic wait_results_done();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (palette_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic byte_q_t random_bytes(int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) q.insert(q.size(), 8'($urandom));
    return q;
  endfunction

  function automatic byte_q_t ihdr_payload(int len, logic [7:0] color);
    byte_q_t q;
    q = random_bytes(len);
    if (len > 9) q[9] = color;
    return q;
  endfunction

  task automatic add_bytes(ref byte_q_t f, input byte_q_t d);
    foreach (d[i]) f.insert(f.size(), d[i]);
  endtask

  task automatic add_word(ref byte_q_t f, input logic [31:0] w);
    for (int i = 3; i >= 0; i--) f.insert(f.size(), w[8*i +: 8]);
  endtask

  task automatic add_signature(ref byte_q_t f);
    for (int i = 7; i >= 0; i--) f.insert(f.size(), PNG_MAGIC[8*i +: 8]);
  endtask

  task automatic add_chunk(ref byte_q_t f, input logic [31:0] ctype, input byte_q_t data);
    add_word(f, data.size());
    add_word(f, ctype);
    add_bytes(f, data);
    add_word(f, $urandom);
  endtask

  // ---- tests -----------------------------------------------------------------

  task automatic test_signature_checks();
    byte_q_t f;
    f = {8'hFF};
    send_file(f);
    f = {8'h89, CHAR_P, CHAR_N};
    send_file(f);
    f = {8'h00, CHAR_P, CHAR_N, CHAR_G};
    send_file(f);
    f = {8'h89, CHAR_P, CHAR_N, 8'h00, 8'h0D, 8'h0A, 8'h1A, 8'h0A, 8'h00};
    send_file(f);
    f.delete();
    add_signature(f);
    add_word(f, 32'h0);
    f.insert(f.size(), 8'hFF);
    send_file(f);
  endtask

  task automatic test_indexed_palette();
    byte_q_t f;
    add_signature(f);
    add_chunk(f, TYPE_IHDR, ihdr_payload(13, COLOR_INDEXED));
    add_word(f, 32'd9);
    add_word(f, TYPE_PLTE);
    // file ends on the byte that completes the third triple
    add_bytes(f, {8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56});
    send_file(f);
    f.delete();
    add_signature(f);
    add_chunk(f, TYPE_IHDR, ihdr_payload(13, COLOR_INDEXED));
    add_chunk(f, TYPE_PLTE, random_bytes(6));
    add_word(f, 32'h0);
    add_chunk(f, TYPE_PLTE, random_bytes(6));
    send_file(f);
  endtask

  task automatic test_palette_corner_cases();
    byte_q_t f;
    add_signature(f);
    add_chunk(f, TYPE_PLTE, random_bytes(6));
    add_chunk(f, TYPE_IHDR_LC, ihdr_payload(13, COLOR_INDEXED));
    // IHDR too short to hold the color type; its CRC starts with an indexed code
    add_word(f, 32'd9);
    add_word(f, TYPE_IHDR);
    add_bytes(f, random_bytes(9));
    add_word(f, {COLOR_INDEXED, 24'h0});
    add_chunk(f, TYPE_PLTE, random_bytes(3));
    f.insert(f.size(), 8'h00);
    send_file(f);
    f.delete();
    add_signature(f);
    add_chunk(f, TYPE_IHDR, ihdr_payload(13, 8'd2));
    add_chunk(f, TYPE_PLTE, random_bytes(6));
    add_chunk(f, TYPE_IHDR, ihdr_payload(13, COLOR_INDEXED));
    add_chunk(f, TYPE_PLTE, random_bytes(7));
    add_chunk(f, TYPE_PLTE, random_bytes(11));
    add_chunk(f, TYPE_PLTE, random_bytes(3));
    void'(f.pop_back());
    send_file(f);
  endtask

  task automatic test_palette_overflow();
    byte_q_t f;
    add_signature(f);
    add_chunk(f, TYPE_IHDR, ihdr_payload(13, COLOR_INDEXED));
    add_chunk(f, TYPE_PLTE, random_bytes(3 * (PAL_ENTRIES + 2) + 1));
    add_word(f, 32'h0);
    send_file(f);
  endtask

  task automatic test_output_backpressure();
    byte_q_t f;
    src_idle     = 0;
    snk_idle     = 0;
    hold_request = HOLD_CYCLES;
    add_signature(f);
    add_chunk(f, TYPE_IHDR, ihdr_payload(13, COLOR_INDEXED));
    add_chunk(f, TYPE_PLTE, random_bytes(72));
    send_file(f);
    wait_results_done();
  endtask

  task automatic test_random_files(input int quota);
    byte_q_t f;
    int      start;
    int      n_chunks;
    int      pick;
    int      cut;
    start = bytes_sent;
    while (bytes_sent - start < quota) begin
      f.delete();
      if ($urandom_range(0, 9) == 0) begin
        f = random_bytes($urandom_range(1, 24));
      end else begin
        add_signature(f);
        if ($urandom_range(0, 9) == 0) f[$urandom_range(1, 3)] = 8'($urandom);
        if ($urandom_range(0, 3) == 0) f[0] = 8'($urandom);
        n_chunks = $urandom_range(1, 4);
        for (int c = 0; c < n_chunks; c++) begin
          pick = $urandom_range(0, 7);
          if (pick < 2) begin
            add_chunk(f, TYPE_IHDR,
                      ihdr_payload($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 13,
                                   $urandom_range(0, 3) == 0 ? 8'($urandom) : COLOR_INDEXED));
          end else if (pick < 6) begin
            add_chunk(f, TYPE_PLTE,
                      random_bytes(3 * $urandom_range(1, 6) +
                                   ($urandom_range(0, 4) == 0 ? $urandom_range(1, 2) : 0)));
          end else if (pick == 6) begin
            add_chunk(f, $urandom, random_bytes($urandom_range(1, 6)));
          end else begin
            // arbitrary length, file ends well inside the data
            add_word(f, $urandom);
            add_word(f, $urandom_range(0, 1) ? TYPE_PLTE : TYPE_IHDR);
            add_bytes(f, random_bytes($urandom_range(0, 8)));
            break;
          end
        end
        if ($urandom_range(0, 2) == 0) begin
          add_word(f, 32'h0);
          add_bytes(f, random_bytes($urandom_range(0, 6)));
        end
        if ($urandom_range(0, 4) == 0) begin
          cut = $urandom_range(1, f.size());
          while (f.size() > cut) void'(f.pop_back());
        end
      end
      send_file(f);
    end
    wait_results_done();
  endtask

  initial begin
    clear_tracker();
    src_idle          = 31;
    snk_idle          = 61;
    hold_request      = 0;
    bytes_sent        = 0;
    mismatches        = 0;
    stall_cycles      = 0;
    rst               <= 1'b1;
    byte_ch.valid     <= 1'b0;
    byte_ch.file_byte <= '0;
    byte_ch.last_byte <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_signature_checks();
    test_indexed_palette();
    test_palette_corner_cases();
    test_palette_overflow();
    wait_results_done();
    test_output_backpressure();

    src_idle = 31;
    snk_idle = 61;
    test_random_files(130);
    src_idle = 61;
    snk_idle = 31;
    test_random_files(130);
    src_idle = 0;
    snk_idle = 0;
    test_random_files(140);

    wait_results_done();
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
